// File: rtl/gddn_pkg.sv
// Shared constants, types and calendar tables for the Gregorian date to
// Julian day number pipeline. No dependencies.
`timescale 1ns / 1ps

package gddn_pkg;

    // Width of the signed year input. Valid range is 12 to 32.
    localparam int YEAR_BITS = 19;
    // Width of the signed day number result.
    localparam int JDN_BITS = 28;
    // Julian day number of January 0, year 0.
    localparam int JDN_JAN0_YEAR0 = 1721059;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_MONTH = 2'd1;
    localparam logic [1:0] STATUS_BAD_DAY   = 2'd2;

    // Century split of a year: floor(year / 100) and a flag that is set when
    // the year is not a whole multiple of 100.
    typedef struct packed {
        logic signed [YEAR_BITS-5:0] q100;
        logic                        nz;
    } cent_t;

    // Days of the common year before the first of the month (index 0 is January).
    function automatic logic [8:0] days_before_month(input logic [3:0] mi);
        logic [8:0] d;
        case (mi)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Length of the month in a common year (index 0 is January).
    function automatic logic [4:0] month_length(input logic [3:0] mi);
        logic [4:0] l;
        case (mi)
            4'd1:    l = 5'd28;
            4'd3:    l = 5'd30;
            4'd5:    l = 5'd30;
            4'd8:    l = 5'd30;
            4'd10:   l = 5'd30;
            default: l = 5'd31;
        endcase
        return l;
    endfunction

endpackage

// File: rtl/gddn_cent_div.sv
// Three-stage floor division of a signed year by 100 using a reciprocal
// multiply and one correction step. Depends on gddn_pkg.
`timescale 1ns / 1ps

module gddn_cent_div
    import gddn_pkg::*;
(
    input  logic                        clk,
    input  logic signed [YEAR_BITS-1:0] year,
    output cent_t                       cent
);

    localparam int VW = YEAR_BITS - 1;
    localparam int QW = YEAR_BITS - 5;
    // Offset in units of 25 that makes floor(year / 4) non-negative.
    localparam longint OFS_M = (64'sd2 ** (YEAR_BITS - 3) + 64'sd24) / 64'sd25;
    localparam longint RECIP = (64'sd2 ** VW) / 64'sd25;
    localparam logic [QW-1:0] RECIP_W = QW'(RECIP);

    // Stage 1: biased quarter year.
    logic signed [YEAR_BITS:0] quarter;
    logic [YEAR_BITS:0]        biased;
    logic [VW-1:0]             v_reg;
    logic [1:0]                ylo_reg;

    assign quarter = (YEAR_BITS+1)'(year >>> 2);
    assign biased  = quarter + (YEAR_BITS+1)'(OFS_M * 64'sd25);

    always_ff @(posedge clk)
    begin
        v_reg   <= biased[VW-1:0];
        ylo_reg <= year[1:0];
    end

    // Stage 2: estimate of the quotient by 25, low by at most one.
    logic [VW+QW-1:0] prod;
    logic [QW-1:0]    q0_reg;
    logic [5:0]       v6_reg;
    logic [1:0]       ylo2_reg;

    assign prod = (VW+QW)'(v_reg) * (VW+QW)'(RECIP_W);

    always_ff @(posedge clk)
    begin
        q0_reg   <= prod[VW+QW-1:VW];
        v6_reg   <= v_reg[5:0];
        ylo2_reg <= ylo_reg;
    end

    // Stage 3: the remainder stays below 50, so six bits and one compare fix it.
    logic [11:0]          m25;
    logic [5:0]           r0;
    logic                 hi;
    logic [QW-1:0]        q;
    logic                 rr_nz;
    logic signed [QW:0]   q100;
    cent_t                cent_next;
    cent_t                cent_reg;

    assign m25   = 12'(q0_reg[5:0]) * 12'd25;
    assign r0    = v6_reg - m25[5:0];
    assign hi    = (r0 >= 6'd25);
    assign q     = q0_reg + QW'(hi);
    assign rr_nz = hi ? (r0 != 6'd25) : (r0 != 6'd0);
    assign q100  = signed'({1'b0, q}) - signed'((QW+1)'(OFS_M));

    always_comb
    begin
        cent_next.q100 = q100;
        cent_next.nz   = rr_nz || (ylo2_reg != 2'd0);
    end

    always_ff @(posedge clk)
    begin
        cent_reg <= cent_next;
    end

    assign cent = cent_reg;

endmodule

// File: rtl/gregorian_date_to_day_number_top.sv
// Gregorian date to Julian day number: five-stage pipeline, one request per cycle.
// Throughput: one request per clock; busy is low in every cycle after reset.
// Reset (rst_n, asynchronous, active low) clears the valid pipeline and holds busy.
// The receiver cannot stall, so results leave on done without any hold-off.
// Depends on gddn_pkg and gddn_cent_div.
`timescale 1ns / 1ps

module gregorian_date_to_day_number_top
    import gddn_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [YEAR_BITS-1:0] year,
    input  logic [3:0]                  month,
    input  logic [5:0]                  day,
    output logic                        done,
    output logic signed [JDN_BITS-1:0]  julian_day_number,
    output logic [1:0]                  status
);

    localparam int JW = JDN_BITS;

    // Per-request data that rides along the pipeline while the century split
    // of the year is worked out in gddn_cent_div.
    typedef struct packed {
        logic [JW-1:0] base;      // 365 * year + floor((year + 3) / 4), wrapped
        logic [8:0]    doy;       // days before the month plus the day
        logic [4:0]    mlen;      // common-year month length
        logic [5:0]    day;
        logic          is_feb;
        logic          after_feb;
        logic          month_ok;
        logic          y_div4;
    } stage_t;

    logic   acc;
    logic   busy_reg;
    logic   v1_reg, v2_reg, v3_reg, v4_reg, done_reg;
    stage_t s1_next, s1_reg, s2_reg, s3_reg;
    cent_t  cent;

    assign acc  = start && !busy_reg;
    assign busy = busy_reg;

    // Busy only covers reset; afterwards a request is taken every cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            v1_reg   <= acc;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // Stage 1: the linear part of the year count and the month lookups.
    // All day sums are taken modulo 2**JW, which matches the wrapped result.
    logic signed [YEAR_BITS:0] yp3;
    logic [3:0]                mi;

    assign yp3 = (YEAR_BITS+1)'(year) + (YEAR_BITS+1)'(3);
    assign mi  = month - 4'd1;

    always_comb
    begin
        s1_next.base      = JW'(year) * JW'(365) + JW'(yp3 >>> 2);
        s1_next.doy       = days_before_month(mi) + 9'(day);
        s1_next.mlen      = month_length(mi);
        s1_next.day       = day;
        s1_next.is_feb    = (month == 4'd2);
        s1_next.after_feb = (month > 4'd2);
        s1_next.month_ok  = (month >= 4'd1) && (month <= 4'd12);
        s1_next.y_div4    = (year[1:0] == 2'd0);
    end

    gddn_cent_div u_cent_div (
        .clk  (clk),
        .year (year),
        .cent (cent)
    );

    // Stages 1 to 3 only carry the payload until the century split is ready.
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s1_reg;
        s3_reg <= s2_reg;
    end

    // Stage 4: leap year rule, century corrections and the status code.
    // With q = floor(year / 100) and nz set when year is not a multiple of 100,
    // floor((year + 99) / 100) = q + nz and
    // floor((year + 399) / 400) = floor(q / 4) + (nz or q not a multiple of 4).
    logic signed [YEAR_BITS-5:0] q100;
    logic [1:0]                  q_lo;
    logic                        leap;
    logic [JW-1:0]               fl100;
    logic [JW-1:0]               fl400;
    logic [5:0]                  mlen_eff;
    logic [JW-1:0]               corr_next;
    logic [1:0]                  status_next;
    logic [JW-1:0]               corr_reg;
    logic [JW-1:0]               base4_reg;
    logic                        month_ok4_reg;
    logic [1:0]                  status4_reg;

    assign q100     = signed'(cent.q100);
    assign q_lo     = q100[1:0];
    assign leap     = s3_reg.y_div4 && (cent.nz || (q_lo == 2'd0));
    assign fl100    = JW'(q100) + JW'(cent.nz);
    assign fl400    = JW'(q100 >>> 2) + JW'(cent.nz || (q_lo != 2'd0));
    assign mlen_eff = 6'(s3_reg.mlen) + 6'(leap && s3_reg.is_feb);

    assign corr_next = fl400 - fl100 + JW'(leap && s3_reg.after_feb)
                     + JW'(s3_reg.doy) + JW'(JDN_JAN0_YEAR0);

    always_comb
    begin
        if (!s3_reg.month_ok)
        begin
            status_next = STATUS_BAD_MONTH;
        end
        else if ((s3_reg.day == 6'd0) || (s3_reg.day > mlen_eff))
        begin
            status_next = STATUS_BAD_DAY;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        corr_reg      <= corr_next;
        base4_reg     <= s3_reg.base;
        month_ok4_reg <= s3_reg.month_ok;
        status4_reg   <= status_next;
    end

    // Stage 5: final sum; a bad month reports a day number of zero.
    logic [JW-1:0] jdn_next;
    logic [JW-1:0] jdn_reg;
    logic [1:0]    status_reg;

    assign jdn_next = month_ok4_reg ? (base4_reg + corr_reg) : '0;

    always_ff @(posedge clk)
    begin
        jdn_reg    <= jdn_next;
        status_reg <= status4_reg;
    end

    assign done              = done_reg;
    assign julian_day_number = signed'(jdn_reg);
    assign status            = status_reg;

    // Every result strobe is matched by a request that was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(acc, 5))
        else $error("result strobe without a matching request");

    // A bad month always reports a zero day number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_BAD_MONTH)) |-> (julian_day_number == '0))
        else $error("bad month with nonzero day number");

    // The status code never takes the unused value.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == STATUS_OK) || (status == STATUS_BAD_MONTH)
                  || (status == STATUS_BAD_DAY)))
        else $error("undefined status code");

    // The century correction stage only sees a valid request (v3_reg) where one
    // was taken and passed along v1_reg and v2_reg.
    assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> $past(acc, 3))
        else $error("valid bit out of step with the century divider");

endmodule

// File: tb/sv/gregorian_date_to_day_number_top_tb.sv
// Self-checking testbench for gregorian_date_to_day_number_top: directed dates,
// then random dates under several sender idle patterns, checked by a predictor.
// Depends on gddn_pkg and the RTL of the block.
`timescale 1ns / 1ps

module gregorian_date_to_day_number_top_tb;

    import gddn_pkg::*;

    // The cycle limit leaves a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PER_STEP = 232;
    localparam int SETTLE_CYCLES   = 12;
    localparam int NUM_DIRECTED    = 24;

    // One expected result: the day number and its status.
    typedef struct packed {
        logic signed [JDN_BITS-1:0] jdn;
        logic [1:0]                 status;
    } day_result_t;

    // One row of the directed stimulus. Where known is set, the expected result
    // is taken from the row; otherwise the predictor supplies it.
    typedef struct {
        int         y;
        int         m;
        int         d;
        bit         known;
        int         jdn;
        logic [1:0] st;
    } date_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [YEAR_BITS-1:0] year;
    logic [3:0]                  month;
    logic [5:0]                  day;
    logic                        done;
    logic signed [JDN_BITS-1:0]  julian_day_number;
    logic [1:0]                  status;

    // Results still owed by the block, oldest first.
    day_result_t pending_day_numbers [$];
    // Expected result of the request that is on the inputs right now.
    day_result_t next_day_number;
    // Set at each rising edge when a request was taken; read at the falling edge.
    bit          took_request = 1'b0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          idle_pct;

    // Directed dates: extremes of every field, all bad month codes, leap year
    // rules for centuries and for negative years, day zero, and days past the
    // end of the month. Typed-in values are those that are plain to see.
    date_row_t directed_rows [0:NUM_DIRECTED-1] = '{
        '{2000,    1,  1, 1, 2451545, STATUS_OK},
        '{0,       1,  1, 1, 1721060, STATUS_OK},
        '{-1,     12, 31, 1, 1721059, STATUS_OK},
        '{1582,   10, 15, 1, 2299161, STATUS_OK},
        '{0,       0,  1, 1, 0,       STATUS_BAD_MONTH},
        '{5,      13, 10, 1, 0,       STATUS_BAD_MONTH},
        '{-262144, 15, 63, 1, 0,      STATUS_BAD_MONTH},
        '{262143,  0,  0, 1, 0,       STATUS_BAD_MONTH},
        '{1999,   14, 20, 1, 0,       STATUS_BAD_MONTH},
        '{0,       2, 29, 0, 0,       STATUS_OK},
        '{1900,    2, 29, 0, 0,       STATUS_OK},
        '{2000,    2, 29, 0, 0,       STATUS_OK},
        '{2000,    2, 30, 0, 0,       STATUS_OK},
        '{2024,    3,  0, 0, 0,       STATUS_OK},
        '{2023,   12, 31, 0, 0,       STATUS_OK},
        '{2023,    4, 31, 0, 0,       STATUS_OK},
        '{-262144,  1,  1, 0, 0,      STATUS_OK},
        '{262143, 12, 31, 0, 0,       STATUS_OK},
        '{262143, 12, 63, 0, 0,       STATUS_OK},
        '{-100,    2, 29, 0, 0,       STATUS_OK},
        '{-400,    2, 29, 0, 0,       STATUS_OK},
        '{-4,      2, 29, 0, 0,       STATUS_OK},
        '{-1,      2, 29, 0, 0,       STATUS_OK},
        '{100,     6, 63, 0, 0,       STATUS_OK}
    };

    gregorian_date_to_day_number_top DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .year              (year),
        .month             (month),
        .day               (day),
        .done              (done),
        .julian_day_number (julian_day_number),
        .status            (status)
    );

    always #10 clk = ~clk;

    // Floor division; the language's own division truncates toward zero, which
    // is wrong for the negative years.
    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic bit is_leap_year(input longint y);
        if (y % 100 == 0)
            return (y % 400) == 0;
        return (y % 4) == 0;
    endfunction

    // Length of month m (1..12) in year y, with the leap February.
    function automatic int days_in_month(input longint y, input logic [3:0] m);
        int n;
        case (m)
            4'd2:    n = is_leap_year(y) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 30;
            default: n = 31;
        endcase
        return n;
    endfunction

    // Days of a common year that come before the first of month m (1..12).
    function automatic int days_before_first(input logic [3:0] m);
        int n;
        case (m)
            4'd2:    n = 31;
            4'd3:    n = 59;
            4'd4:    n = 90;
            4'd5:    n = 120;
            4'd6:    n = 151;
            4'd7:    n = 181;
            4'd8:    n = 212;
            4'd9:    n = 243;
            4'd10:   n = 273;
            4'd11:   n = 304;
            4'd12:   n = 334;
            default: n = 0;
        endcase
        return n;
    endfunction

    // Predicts the block's answer for one date. A bad day still yields the day
    // number counted straight on from the given day; a bad month yields zero.
    function automatic day_result_t calc_day_number(input logic signed [YEAR_BITS-1:0] y,
                                                    input logic [3:0] m,
                                                    input logic [5:0] d);
        longint      yl;
        longint      total;
        day_result_t r;
        yl = y;
        if (m < 4'd1 || m > 4'd12)
        begin
            r.jdn    = '0;
            r.status = STATUS_BAD_MONTH;
        end
        else
        begin
            r.status = (d == 6'd0 || int'(d) > days_in_month(yl, m)) ? STATUS_BAD_DAY
                                                                      : STATUS_OK;
            total = 365 * yl + floor_quot(yl + 3, 4) - floor_quot(yl + 99, 100)
                  + floor_quot(yl + 399, 400) + days_before_first(m)
                  + ((is_leap_year(yl) && m > 4'd2) ? 1 : 0) + longint'(d)
                  + JDN_JAN0_YEAR0;
            r.jdn = total[JDN_BITS-1:0];
        end
        return r;
    endfunction

    task automatic report_failure(input string what);
        if (mismatches < 10)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Presents one request. Before it, the sender may sit idle for a random
    // number of cycles, according to idle_pct. The task returns at the falling
    // edge after the request was taken, so the next one follows without a gap.
    task automatic issue_date(input logic signed [YEAR_BITS-1:0] y, input logic [3:0] m,
                              input logic [5:0] d, input bit known, input int known_jdn,
                              input logic [1:0] known_status);
        day_result_t r;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        if (known)
        begin
            r.jdn    = JDN_BITS'(known_jdn);
            r.status = known_status;
        end
        else
            r = calc_day_number(y, m, d);
        next_day_number = r;
        start <= 1'b1;
        year  <= y;
        month <= m;
        day   <= d;
        @(negedge clk);
        while (!took_request)
            @(negedge clk);
    endtask

    // Random year: full range, dates near the present, century and 400-year
    // boundaries, values near the ends of the range, and years close to zero.
    function automatic logic signed [YEAR_BITS-1:0] pick_year();
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = int'($urandom_range(0, 4000)) - 2000;
            2: v = (int'($urandom_range(0, 5242)) - 2621) * 100;
            3: v = (int'($urandom_range(0, 1310)) - 655) * 400;
            4: v = $urandom_range(0, 1) ? (-262144 + int'($urandom_range(0, 8)))
                                        : (262143 - int'($urandom_range(0, 8)));
            default: v = int'($urandom_range(0, 20)) - 10;
        endcase
        return v[YEAR_BITS-1:0];
    endfunction

    // Mostly valid dates with random content, some days at or just past the end
    // of the month, some day zero, some raw days, and a few bad month codes.
    task automatic issue_random_date();
        logic signed [YEAR_BITS-1:0] y;
        logic [3:0]                  m;
        logic [5:0]                  d;
        int                          len;
        int                          pick;
        y = pick_year();
        if ($urandom_range(0, 99) < 8)
        begin
            pick = $urandom_range(0, 3);
            m = (pick == 0) ? 4'd0 : 4'(12 + pick);
        end
        else
            m = 4'($urandom_range(1, 12));
        len  = days_in_month(longint'(y), m);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            d = 6'($urandom_range(1, len));
        else if (pick < 80)
            d = 6'(len);
        else if (pick < 85)
            d = 6'(len + 1);
        else if (pick < 90)
            d = 6'd0;
        else
            d = 6'($urandom_range(0, 63));
        issue_date(y, m, d, 1'b0, 0, STATUS_OK);
    endtask

    // Result checker and request tracker. Both run at the rising edge, where
    // the inputs (driven at the falling edge) and the registered outputs are
    // stable, so nothing here depends on the order of events at the edge.
    always @(posedge clk)
    begin
        day_result_t want;
        took_request = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_day_numbers.size() == 0)
                    report_failure($sformatf(
                        "result with no request waiting: jdn %0d status %0d",
                        julian_day_number, status));
                else
                begin
                    want = pending_day_numbers.pop_front();
                    if (julian_day_number !== want.jdn || status !== want.status)
                        report_failure($sformatf(
                            "expected jdn %0d status %0d, got jdn %0d status %0d",
                            want.jdn, want.status, julian_day_number, status));
                end
            end
            if (start && !busy)
            begin
                pending_day_numbers.push_back(next_day_number);
                took_request = 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** gregorian_date_to_day_number_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int step_idle [4];
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        year            = '0;
        month           = '0;
        day             = '0;
        idle_pct        = 0;
        next_day_number = '0;

        // The sender idle patterns for the random part: none, heavy, none again
        // (the receiver side cannot stall, so its phase has no idling), and mixed.
        step_idle = '{0, 67, 0, 35};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, sent back to back.
        for (int i = 0; i < NUM_DIRECTED; i++)
            issue_date(directed_rows[i].y[YEAR_BITS-1:0], 4'(directed_rows[i].m),
                       6'(directed_rows[i].d), directed_rows[i].known,
                       directed_rows[i].jdn, directed_rows[i].st);

        for (int p = 0; p < 4; p++)
        begin
            // The sender holds off until every result owed so far has come out,
            // so each phase starts from an empty pipeline.
            start <= 1'b0;
            while (pending_day_numbers.size() != 0)
                @(negedge clk);
            idle_pct = step_idle[p];
            for (int i = 0; i < RANDOM_PER_STEP; i++)
                issue_random_date();
        end

        start <= 1'b0;
        while (pending_day_numbers.size() != 0)
            @(negedge clk);
        // Run on for longer than the pipeline depth to catch a stray result.
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (pending_day_numbers.size() != 0)
            report_failure($sformatf("%0d results never arrived", pending_day_numbers.size()));

        if (mismatches == 0)
            $display("** gregorian_date_to_day_number_top: PASSED **");
        else
            $display("** gregorian_date_to_day_number_top: FAILED **");
        $finish;
    end

endmodule
